// ===== rtl/modular_arithmetic_unit_top_defines.svh =====
// Assertion macros for the modular arithmetic unit.
// Included by the top level; depends on nothing else.
`ifndef MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked on every rising clock edge outside reset.
`define MAU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define MAU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MAU_ASSERT(label, prop, msg)
`define MAU_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/mau_pkg.sv =====
// Shared types, constants and the microprogram of the modular arithmetic unit.
// Used by every module of the block; depends on nothing.
package mau_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 30;
   localparam logic [63:0] MODULUS_RESET = 64'd998244353;

   // Operation codes carried by an input beat.
   localparam logic [2:0] KIND_ADD = 3'd0;
   localparam logic [2:0] KIND_SUB = 3'd1;
   localparam logic [2:0] KIND_MUL = 3'd2;
   localparam logic [2:0] KIND_DIV = 3'd3;
   localparam logic [2:0] KIND_POW = 3'd4;

   localparam int PC_W = 5;

   // Microprogram addresses.
   localparam logic [PC_W-1:0] PC_CHECK    = 5'd0;
   localparam logic [PC_W-1:0] PC_RED_A    = 5'd1;
   localparam logic [PC_W-1:0] PC_RED_B    = 5'd2;
   localparam logic [PC_W-1:0] PC_DISPATCH = 5'd3;
   localparam logic [PC_W-1:0] PC_ADD      = 5'd4;
   localparam logic [PC_W-1:0] PC_SUB      = 5'd5;
   localparam logic [PC_W-1:0] PC_MUL      = 5'd6;
   localparam logic [PC_W-1:0] PC_DIV      = 5'd7;
   localparam logic [PC_W-1:0] PC_DIV_LOAD = 5'd8;
   localparam logic [PC_W-1:0] PC_POW      = 5'd9;
   localparam logic [PC_W-1:0] PC_LOOP     = 5'd10;
   localparam logic [PC_W-1:0] PC_ODD      = 5'd11;
   localparam logic [PC_W-1:0] PC_MUL_ACC  = 5'd12;
   localparam logic [PC_W-1:0] PC_SQR      = 5'd13;
   localparam logic [PC_W-1:0] PC_POW_END  = 5'd14;
   localparam logic [PC_W-1:0] PC_FINAL    = 5'd15;
   localparam logic [PC_W-1:0] PC_EMIT     = 5'd16;
   localparam logic [PC_W-1:0] PC_ZERO     = 5'd17;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_RED_A,      // a = a mod m (engine)
      UOP_RED_B,      // b = b mod m (engine)
      UOP_ADD,        // acc = (a + b) mod m
      UOP_SUB,        // acc = (a - b) mod m
      UOP_MUL_AB,     // acc = a * b mod m (engine)
      UOP_LOAD_POW,   // base = a, e = b, acc = 1
      UOP_LOAD_DIV,   // base = b, e = m - 2, acc = 1
      UOP_MUL_ACC,    // acc = acc * base mod m (engine)
      UOP_SQR,        // base = base * base mod m, e = e >> 1 (engine)
      UOP_MUL_ACC_A,  // acc = acc * a mod m (engine)
      UOP_CLR_ACC,    // acc = 0
      UOP_EMIT        // present acc as the result
   } uop_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_M_LT2,
      C_B_ZERO,
      C_E_ZERO,
      C_E_EVEN,
      C_KIND_POW,
      C_DISPATCH
   } cond_type;

   typedef enum logic {
      ENG_RED,
      ENG_MUL
   } eng_mode_type;

   typedef struct packed {
      uop_type          uop;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctrl_word_type;

   typedef struct packed {
      logic    load;
      uop_type op;
      logic    go;
   } dp_ctrl_type;

   typedef struct packed {
      logic unit_done;
      logic m_lt2;
      logic b_zero;
      logic e_zero;
      logic e_odd;
   } dp_status_type;

   function automatic logic uses_engine(input uop_type op);
      return (op == UOP_RED_A) || (op == UOP_RED_B) || (op == UOP_MUL_AB) ||
             (op == UOP_MUL_ACC) || (op == UOP_SQR) || (op == UOP_MUL_ACC_A);
   endfunction

   function automatic logic [PC_W-1:0] dispatch_pc(input logic [2:0] kind);
      logic [PC_W-1:0] pc;
      case (kind)
         KIND_ADD: pc = PC_ADD;
         KIND_SUB: pc = PC_SUB;
         KIND_MUL: pc = PC_MUL;
         KIND_DIV: pc = PC_DIV;
         KIND_POW: pc = PC_POW;
         default:  pc = PC_ZERO;
      endcase
      return pc;
   endfunction

   function automatic ctrl_word_type rom_word(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      unique case (pc)
         PC_CHECK:    w = '{uop: UOP_NOP,       cond: C_M_LT2,    target: PC_ZERO};
         PC_RED_A:    w = '{uop: UOP_RED_A,     cond: C_NEXT,     target: PC_CHECK};
         PC_RED_B:    w = '{uop: UOP_RED_B,     cond: C_NEXT,     target: PC_CHECK};
         PC_DISPATCH: w = '{uop: UOP_NOP,       cond: C_DISPATCH, target: PC_CHECK};
         PC_ADD:      w = '{uop: UOP_ADD,       cond: C_ALWAYS,   target: PC_EMIT};
         PC_SUB:      w = '{uop: UOP_SUB,       cond: C_ALWAYS,   target: PC_EMIT};
         PC_MUL:      w = '{uop: UOP_MUL_AB,    cond: C_ALWAYS,   target: PC_EMIT};
         PC_DIV:      w = '{uop: UOP_NOP,       cond: C_B_ZERO,   target: PC_ZERO};
         PC_DIV_LOAD: w = '{uop: UOP_LOAD_DIV,  cond: C_ALWAYS,   target: PC_LOOP};
         PC_POW:      w = '{uop: UOP_LOAD_POW,  cond: C_NEXT,     target: PC_CHECK};
         PC_LOOP:     w = '{uop: UOP_NOP,       cond: C_E_ZERO,   target: PC_POW_END};
         PC_ODD:      w = '{uop: UOP_NOP,       cond: C_E_EVEN,   target: PC_SQR};
         PC_MUL_ACC:  w = '{uop: UOP_MUL_ACC,   cond: C_NEXT,     target: PC_CHECK};
         PC_SQR:      w = '{uop: UOP_SQR,       cond: C_ALWAYS,   target: PC_LOOP};
         PC_POW_END:  w = '{uop: UOP_NOP,       cond: C_KIND_POW, target: PC_EMIT};
         PC_FINAL:    w = '{uop: UOP_MUL_ACC_A, cond: C_NEXT,     target: PC_CHECK};
         PC_EMIT:     w = '{uop: UOP_EMIT,      cond: C_NEXT,     target: PC_CHECK};
         PC_ZERO:     w = '{uop: UOP_CLR_ACC,   cond: C_ALWAYS,   target: PC_EMIT};
         default:     w = '{uop: UOP_CLR_ACC,   cond: C_ALWAYS,   target: PC_EMIT};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/modular_arithmetic_unit_top.sv =====
// Top level of the modular arithmetic unit: sequencer, datapath and assertions.
// Depends on mau_pkg, mau_seq, mau_datapath and modular_arithmetic_unit_top_defines.svh.
//
// Usage. A command beat is taken at a rising clock edge where start is high and busy is
// low; it carries req_kind (0 add, 1 subtract, 2 multiply, 3 divide, 4 power, other codes
// give 0) and the operands req_operand_a and req_operand_b. Both operands are reduced
// modulo the configured modulus before use. The one result beat appears on rsp_result for
// exactly one cycle with rsp_strobe high; the receiver cannot stall it, so it must take it.
// The modulus is written through the csr_ channel, which is ready whenever the unit is
// idle. A modulus below two makes every result 0; divide uses the Fermat inverse and is
// meaningful only for a prime modulus, and division by zero returns 0.
//
// Flow. One iterative engine does every remainder and every product; a product ends once
// no set bit of its multiplier is left. After the accepting edge busy stays high until
// the result beat, which comes with busy already low, so the next command can be taken
// at the edge that ends it. Reset clears the sequencer and loads 998244353.
`include "modular_arithmetic_unit_top_defines.svh"

module modular_arithmetic_unit_top
   import mau_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Command channel.
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_kind,
   input  logic [VALUE_WIDTH-1:0] req_operand_a,
   input  logic [VALUE_WIDTH-1:0] req_operand_b,
   // Result channel.
   output logic                   rsp_strobe,
   output logic [VALUE_WIDTH-1:0] rsp_result,
   // Modulus write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [VALUE_WIDTH-1:0] csr_modulus
);

   dp_ctrl_type   ctrl;
   dp_status_type status;
   logic          csr_we;

   // The modulus may change only between commands.
   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;

   // The sequencer steps through the control ROM and drives the datapath word by word.
   mau_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .ctrl     (ctrl),
      .busy     (busy),
      .strobe   (rsp_strobe)
   );

   // The datapath holds the operands, exponent, base, accumulator and modulus; its
   // accumulator is the result register and stays put until the next command computes.
   mau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_a    (req_operand_a),
      .req_b    (req_operand_b),
      .csr_we   (csr_we),
      .csr_data (csr_modulus),
      .status   (status),
      .result   (rsp_result)
   );

   // A result beat only ends a command that was running.
   `MAU_ASSERT(a_strobe_after_busy, rsp_strobe |-> (!busy && $past(busy)), "stray result beat")
   // An accepted command keeps the unit busy in the next cycle.
   `MAU_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted command did not start")
   // Every result beat lasts exactly one cycle.
   `MAU_ASSERT(a_strobe_single, rsp_strobe |=> !rsp_strobe, "result beat longer than one cycle")
   // Reset leaves the unit idle, with no result beat reported.
   `MAU_ASSERT_ALWAYS(a_reset_quiet, reset |=> (!rsp_strobe && !busy), "busy after reset")

endmodule

// ===== rtl/mau_engine.sv =====
// Iterative modular engine: remainder by restoring steps, or product by shift-and-add.
// Depends on mau_pkg.
module mau_engine
   import mau_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  eng_mode_type           mode,
   input  logic [VALUE_WIDTH-1:0] x,
   input  logic [VALUE_WIDTH-1:0] y,
   input  logic [VALUE_WIDTH-1:0] modulus,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] res
);

   localparam int W = VALUE_WIDTH;
   localparam int CNT_W = $clog2(W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   eng_mode_type       mode_ff, mode_in;
   logic [W-1:0]       acc_ff, acc_in;
   logic [W-1:0]       xs_ff, xs_in;
   logic [W-1:0]       ys_ff, ys_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [W:0] mod_ext, t, red_next, s, add_next, d, dbl_next;
   logic       finish;

   always_comb begin
      mod_ext  = {1'b0, modulus};
      // Restoring remainder step: shift in the next dividend bit, subtract if it fits.
      t        = {acc_ff, ys_ff[W-1]};
      red_next = (t >= mod_ext) ? (t - mod_ext) : t;
      // Shift-and-add product step: accumulate and double, each kept below m.
      s        = {1'b0, acc_ff} + {1'b0, xs_ff};
      add_next = (s >= mod_ext) ? (s - mod_ext) : s;
      d        = {xs_ff, 1'b0};
      dbl_next = (d >= mod_ext) ? (d - mod_ext) : d;
      finish   = (mode_ff == ENG_RED) ? (cnt_ff == '0) : (ys_ff == '0);

      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      acc_in  = acc_ff;
      xs_in   = xs_ff;
      ys_in   = ys_ff;
      cnt_in  = cnt_ff;
      if (!busy_ff) begin
         if (go) begin
            busy_in = 1'b1;
            mode_in = mode;
            acc_in  = '0;
            xs_in   = x;
            ys_in   = y;
            cnt_in  = CNT_W'(W);
         end
      end else if (finish) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end else begin
         unique case (mode_ff)
            ENG_RED: begin
               acc_in = red_next[W-1:0];
               ys_in  = ys_ff << 1;
               cnt_in = cnt_ff - 1'b1;
            end
            ENG_MUL: begin
               if (ys_ff[0]) begin
                  acc_in = add_next[W-1:0];
               end
               xs_in = dbl_next[W-1:0];
               ys_in = ys_ff >> 1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= ENG_RED;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      xs_ff  <= xs_in;
      ys_ff  <= ys_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign res  = acc_ff;

endmodule

// ===== rtl/mau_datapath.sv =====
// Operand, power and accumulator registers with the modulus register and the engine.
// Depends on mau_pkg and mau_engine.
module mau_datapath
   import mau_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_ctrl_type            ctrl,
   input  logic [VALUE_WIDTH-1:0] req_a,
   input  logic [VALUE_WIDTH-1:0] req_b,
   input  logic                   csr_we,
   input  logic [VALUE_WIDTH-1:0] csr_data,
   output dp_status_type          status,
   output logic [VALUE_WIDTH-1:0] result
);

   localparam int W = VALUE_WIDTH;

   logic [W-1:0] modulus_ff;
   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] e_ff, e_in;
   logic [W-1:0] acc_ff, acc_in;

   eng_mode_type eng_mode;
   logic [W-1:0] eng_x, eng_y, eng_res;
   logic         eng_done;
   logic [W:0]   sum, sum_red, diff;

   mau_engine #(.VALUE_WIDTH(W)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .go      (ctrl.go),
      .mode    (eng_mode),
      .x       (eng_x),
      .y       (eng_y),
      .modulus (modulus_ff),
      .done    (eng_done),
      .res     (eng_res)
   );

   // Engine operand selection; x must already be below the modulus for a product.
   always_comb begin
      eng_mode = ENG_MUL;
      eng_x    = base_ff;
      eng_y    = acc_ff;
      case (ctrl.op)
         UOP_RED_A: begin
            eng_mode = ENG_RED;
            eng_y    = a_ff;
         end
         UOP_RED_B: begin
            eng_mode = ENG_RED;
            eng_y    = b_ff;
         end
         UOP_MUL_AB: begin
            eng_x = a_ff;
            eng_y = b_ff;
         end
         UOP_SQR: begin
            eng_y = base_ff;
         end
         UOP_MUL_ACC_A: begin
            eng_x = a_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sum     = {1'b0, a_ff} + {1'b0, b_ff};
      sum_red = (sum >= {1'b0, modulus_ff}) ? (sum - {1'b0, modulus_ff}) : sum;
      diff    = (a_ff >= b_ff) ? ({1'b0, a_ff} - {1'b0, b_ff})
                               : ({1'b0, a_ff} + {1'b0, modulus_ff} - {1'b0, b_ff});

      a_in    = a_ff;
      b_in    = b_ff;
      base_in = base_ff;
      e_in    = e_ff;
      acc_in  = acc_ff;
      if (ctrl.load) begin
         a_in = req_a;
         b_in = req_b;
      end else begin
         case (ctrl.op)
            UOP_RED_A:     if (eng_done) a_in = eng_res;
            UOP_RED_B:     if (eng_done) b_in = eng_res;
            UOP_ADD:       acc_in = sum_red[W-1:0];
            UOP_SUB:       acc_in = diff[W-1:0];
            UOP_MUL_AB:    if (eng_done) acc_in = eng_res;
            UOP_LOAD_POW: begin
               base_in = a_ff;
               e_in    = b_ff;
               acc_in  = W'(1);
            end
            UOP_LOAD_DIV: begin
               base_in = b_ff;
               e_in    = modulus_ff - W'(2);
               acc_in  = W'(1);
            end
            UOP_MUL_ACC:   if (eng_done) acc_in = eng_res;
            UOP_SQR: begin
               if (eng_done) begin
                  base_in = eng_res;
                  e_in    = e_ff >> 1;
               end
            end
            UOP_MUL_ACC_A: if (eng_done) acc_in = eng_res;
            UOP_CLR_ACC:   acc_in = '0;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[W-1:0];
      end else if (csr_we) begin
         modulus_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      base_ff <= base_in;
      e_ff    <= e_in;
      acc_ff  <= acc_in;
   end

   assign status.unit_done = eng_done;
   assign status.m_lt2     = (modulus_ff < W'(2));
   assign status.b_zero    = (b_ff == '0);
   assign status.e_zero    = (e_ff == '0);
   assign status.e_odd     = e_ff[0];
   assign result           = acc_ff;

endmodule

// ===== rtl/mau_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on mau_pkg.
module mau_seq
   import mau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [2:0]    req_kind,
   input  dp_status_type status,
   output dp_ctrl_type   ctrl,
   output logic          busy,
   output logic          strobe
);

   logic            busy_ff, busy_in;
   logic            strobe_ff, strobe_in;
   logic            launched_ff, launched_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [2:0]      kind_ff, kind_in;

   ctrl_word_type   word;
   logic            take, engine_op, step_done, taken;
   logic [PC_W-1:0] jump_pc;

   always_comb begin
      word      = rom_word(pc_ff);
      take      = start && !busy_ff;
      engine_op = uses_engine(word.uop);
      step_done = engine_op ? (launched_ff && status.unit_done) : 1'b1;

      jump_pc = word.target;
      unique case (word.cond)
         C_NEXT:     taken = 1'b0;
         C_ALWAYS:   taken = 1'b1;
         C_M_LT2:    taken = status.m_lt2;
         C_B_ZERO:   taken = status.b_zero;
         C_E_ZERO:   taken = status.e_zero;
         C_E_EVEN:   taken = !status.e_odd;
         C_KIND_POW: taken = (kind_ff == KIND_POW);
         C_DISPATCH: begin
            taken   = 1'b1;
            jump_pc = dispatch_pc(kind_ff);
         end
         default:    taken = 1'b0;
      endcase

      busy_in     = busy_ff;
      strobe_in   = 1'b0;
      launched_in = launched_ff;
      pc_in       = pc_ff;
      kind_in     = kind_ff;
      if (take) begin
         busy_in     = 1'b1;
         launched_in = 1'b0;
         pc_in       = PC_CHECK;
         kind_in     = req_kind;
      end else if (busy_ff) begin
         if (engine_op && !launched_ff) begin
            launched_in = 1'b1;
         end
         if (step_done) begin
            launched_in = 1'b0;
            if (word.uop == UOP_EMIT) begin
               busy_in   = 1'b0;
               strobe_in = 1'b1;
            end else begin
               pc_in = taken ? jump_pc : (pc_ff + 1'b1);
            end
         end
      end

      ctrl.load = take;
      ctrl.op   = busy_ff ? word.uop : UOP_NOP;
      ctrl.go   = busy_ff && engine_op && !launched_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
         launched_ff <= 1'b0;
         pc_ff       <= PC_CHECK;
      end else begin
         busy_ff     <= busy_in;
         strobe_ff   <= strobe_in;
         launched_ff <= launched_in;
         pc_ff       <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign busy   = busy_ff;
   assign strobe = strobe_ff;

endmodule
